### rtl/core/array_list_insert_remove_core_defines.svh
// Assertion macros shared by the core.
`ifndef ARRAY_LIST_INSERT_REMOVE_CORE_DEFINES_SVH
`define ARRAY_LIST_INSERT_REMOVE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ALC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("core assertion failed");

// Next-cycle implication, checked out of reset.
`define ALC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("core assertion failed");

`endif

### rtl/core/alc_pkg.sv
package alc_pkg;

	localparam int CAPACITY = 256;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 9;
	localparam int WORD_W   = 64;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	// read tree: groups of GRP_SZ cells, one registered level per group
	localparam int GRP_SZ   = (CAPACITY >= 64) ? 16 : 2;
	localparam int GSEL_W   = $clog2(GRP_SZ);
	localparam int NGRP     = CAPACITY / GRP_SZ;
	localparam int GIDX_W   = IDX_W - GSEL_W;

	typedef enum logic [1:0] {
		MODE_READ   = 2'd0,
		MODE_WRITE  = 2'd1,
		MODE_INSERT = 2'd2,
		MODE_REMOVE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// broadcast to every cell; strobes are already qualified by the accept
	typedef struct packed {
		logic              wr;
		logic              ins;
		logic              rem;
		logic [IDX_W-1:0]  pos;
		logic [WORD_W-1:0] word;
	} cell_ctrl_t;

endpackage

### rtl/core/alc_req_if.sv
interface alc_req_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                mode;
	logic [alc_pkg::POS_W-1:0] position;
	logic [63:0]               word_in;

	modport source (output valid, output mode, output position, output word_in, input ready);
	modport sink (input valid, input mode, input position, input word_in, output ready);
endinterface

### rtl/core/alc_rsp_if.sv
interface alc_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [63:0]               word_out;
	logic [alc_pkg::POS_W-1:0] entries_held;
	logic [1:0]                status;

	modport source (output valid, output word_out, output entries_held, output status,
		input ready);
	modport sink (input valid, input word_out, input entries_held, input status,
		output ready);
endinterface

### rtl/core/array_list_insert_remove_core.sv
// Pipeline: an accepted item goes through the stage-1 registers, then the output register.
// Throughput: one item per cycle while results are taken; the cell row applies an
//   insert, remove or overwrite in the accept cycle, and a read goes through a
//   two-level registered mux tree over the cells.
// Reset: arst_n clears the entry count and the pipeline valids; cell contents are
//   not reset and are only read below the count, where they have been written.
`include "array_list_insert_remove_core_defines.svh"

module array_list_insert_remove_core (
	input  logic       clk,
	input  logic       arst_n,
	alc_req_if.sink    req,
	alc_rsp_if.source  rsp
);

	localparam int IDX_W  = alc_pkg::IDX_W;
	localparam int CNT_W  = alc_pkg::CNT_W;
	localparam int POS_W  = alc_pkg::POS_W;
	localparam int CMP_W  = alc_pkg::CMP_W;
	localparam int WORD_W = alc_pkg::WORD_W;

	// ---------------------------------------------------------------
	// Request decode against the current count
	// ---------------------------------------------------------------
	logic [CNT_W-1:0]  count_q;
	logic              accept;
	logic [CMP_W-1:0]  pos_x;
	logic [CMP_W-1:0]  cnt_x;
	logic              below;       // position < count
	logic              not_above;   // position <= count
	logic              full;
	alc_pkg::status_t  st_d;
	logic              rd_ok;
	logic [CNT_W-1:0]  count_d;
	alc_pkg::cell_ctrl_t ctrl;

	assign accept    = req.valid && req.ready;
	assign pos_x     = CMP_W'(req.position);
	assign cnt_x     = CMP_W'(count_q);
	assign below     = pos_x < cnt_x;
	assign not_above = pos_x <= cnt_x;
	assign full      = count_q == CNT_W'(alc_pkg::CAPACITY);

	always_comb begin
		st_d      = alc_pkg::ST_OK;
		rd_ok     = 1'b0;
		count_d   = count_q;
		ctrl.wr   = 1'b0;
		ctrl.ins  = 1'b0;
		ctrl.rem  = 1'b0;
		ctrl.pos  = IDX_W'(req.position);
		ctrl.word = req.word_in;
		case (alc_pkg::mode_t'(req.mode))
			alc_pkg::MODE_READ: begin
				if (below) rd_ok = 1'b1;
				else st_d = alc_pkg::ST_RANGE;
			end
			alc_pkg::MODE_WRITE: begin
				if (below) ctrl.wr = accept;
				else st_d = alc_pkg::ST_RANGE;
			end
			alc_pkg::MODE_INSERT: begin
				// range error wins over full
				if (!not_above) begin
					st_d = alc_pkg::ST_RANGE;
				end else if (full) begin
					st_d = alc_pkg::ST_FULL;
				end else begin
					ctrl.ins = accept;
					count_d  = count_q + 1'b1;
				end
			end
			alc_pkg::MODE_REMOVE: begin
				if (below) begin
					ctrl.rem = accept;
					count_d  = count_q - 1'b1;
				end else begin
					st_d = alc_pkg::ST_RANGE;
				end
			end
			default: st_d = alc_pkg::ST_RANGE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	// ---------------------------------------------------------------
	// Cell row: each cell sees its left and right neighbor
	// ---------------------------------------------------------------
	logic [WORD_W-1:0] cell_q [alc_pkg::CAPACITY];

	for (genvar g = 0; g < alc_pkg::CAPACITY; g++) begin : g_cell
		logic [WORD_W-1:0] left_w;
		logic [WORD_W-1:0] right_w;
		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_q[g-1];
		end
		if (g == alc_pkg::CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_q[g+1];
		end
		alc_cell u_cell (
			.clk   (clk),
			.idx   (IDX_W'(g)),
			.ctrl  (ctrl),
			.left  (left_w),
			.right (right_w),
			.word  (cell_q[g])
		);
	end

	// ---------------------------------------------------------------
	// Stage 1: per-group read select, snapshot taken before the update
	// ---------------------------------------------------------------
	logic [alc_pkg::GSEL_W-1:0] gsel;
	logic [WORD_W-1:0]          grp_rd [alc_pkg::NGRP];

	assign gsel = req.position[alc_pkg::GSEL_W-1:0];

	always_comb begin
		for (int k = 0; k < alc_pkg::NGRP; k++) begin
			grp_rd[k] = cell_q[{alc_pkg::GIDX_W'(k), gsel}];
		end
	end

	logic                       v_s1;
	logic                       rd_s1;
	alc_pkg::status_t           st_s1;
	logic [CNT_W-1:0]           cnt_s1;
	logic [alc_pkg::GIDX_W-1:0] grp_sel_s1;
	logic [WORD_W-1:0]          grp_s1 [alc_pkg::NGRP];
	logic                       adv_s1;

	logic                       out_v_q;
	logic [WORD_W-1:0]          word_q;
	logic [CNT_W-1:0]           held_q;
	alc_pkg::status_t           st_q;

	assign adv_s1    = v_s1 && (!out_v_q || rsp.ready);
	assign req.ready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1      <= rd_ok;
			st_s1      <= st_d;
			cnt_s1     <= count_d;
			grp_sel_s1 <= req.position[IDX_W-1:alc_pkg::GSEL_W];
			grp_s1     <= grp_rd;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: group select into the output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv_s1) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			word_q <= rd_s1 ? grp_s1[grp_sel_s1] : '0;
			held_q <= cnt_s1;
			st_q   <= st_s1;
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.word_out     = word_q;
	assign rsp.entries_held = POS_W'(held_q);
	assign rsp.status       = st_q;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	`ALC_ASSERT_IMP(a_cnt_max, 1'b1, count_q <= CNT_W'(alc_pkg::CAPACITY))
	`ALC_ASSERT_NXT(a_cnt_hold, !accept, $stable(count_q))
	`ALC_ASSERT_IMP(a_word_zero, out_v_q && st_q != alc_pkg::ST_OK, word_q == '0)
	`ALC_ASSERT_IMP(a_full_cnt, out_v_q && st_q == alc_pkg::ST_FULL,
		held_q == CNT_W'(alc_pkg::CAPACITY))
	`ALC_ASSERT_NXT(a_rem_dec, ctrl.rem, count_q == $past(count_q) - 1'b1)

endmodule

### rtl/core/alc_cell.sv
module alc_cell (
	input  logic                               clk,
	input  logic [alc_pkg::IDX_W-1:0]          idx,
	input  alc_pkg::cell_ctrl_t                ctrl,
	input  logic [alc_pkg::WORD_W-1:0]         left,
	input  logic [alc_pkg::WORD_W-1:0]         right,
	output logic [alc_pkg::WORD_W-1:0]         word
);

	logic above;
	logic at_pos;

	assign above  = idx > ctrl.pos;
	assign at_pos = idx == ctrl.pos;

	always_ff @(posedge clk) begin
		if (ctrl.ins && above) begin
			word <= left;          // shift up
		end else if ((ctrl.ins || ctrl.wr) && at_pos) begin
			word <= ctrl.word;
		end else if (ctrl.rem && (above || at_pos)) begin
			word <= right;         // shift down
		end
	end

endmodule
